// ===== sv/wfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_pkg
// Types, codes and a helper function shared by the WebSocket deframer files.
// ----------------------------------------------------------------------------
package wfd_pkg;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [2:0] KIND_TEXT    = 3'd0;
    localparam logic [2:0] KIND_BINARY  = 3'd1;
    localparam logic [2:0] KIND_CLOSE   = 3'd2;
    localparam logic [2:0] KIND_PING    = 3'd3;
    localparam logic [2:0] KIND_PONG    = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN = 3'd5;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FRAGMENTED = 2'd1;
    localparam logic [1:0] ST_PEER_CLOSE = 2'd2;
    localparam logic [1:0] ST_DROPPED    = 2'd3;

    localparam logic [1:0] LINK_OPEN    = 2'd0;
    localparam logic [1:0] LINK_CLOSING = 2'd1;
    localparam logic [1:0] LINK_CLOSED  = 2'd2;
    localparam logic [1:0] LINK_ERRORED = 2'd3;

    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] EXT16_BYTES = 4'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       conn_end;
    } rx_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [2:0]  frame_kind;
        logic        last_of_frame;
        logic [1:0]  status;
        logic [15:0] close_code;
        logic [1:0]  link_state;
    } tx_item_t;

    function automatic logic [2:0] kind_of(input logic [3:0] op);
        logic [2:0] k;
        case (op)
            OP_TEXT:   k = KIND_TEXT;
            OP_BINARY: k = KIND_BINARY;
            OP_CLOSE:  k = KIND_CLOSE;
            OP_PING:   k = KIND_PING;
            OP_PONG:   k = KIND_PONG;
            default:   k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

// ===== sv/wfd_rx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_rx_if
// Receive channel: one byte or an end-of-connection event per request.
// ----------------------------------------------------------------------------
interface wfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       conn_end;

    modport source (output valid, output rx_byte, output conn_end, input ready);
    modport sink   (input valid, input rx_byte, input conn_end, output ready);
endinterface

// ===== sv/wfd_tx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_tx_if
// Result channel: one parse result per request.
// ----------------------------------------------------------------------------
interface wfd_tx_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [2:0]  frame_kind;
    logic        last_of_frame;
    logic [1:0]  status;
    logic [15:0] close_code;
    logic [1:0]  link_state;

    modport source (output valid, output out_byte, output byte_valid,
                    output frame_kind, output last_of_frame, output status,
                    output close_code, output link_state, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input frame_kind, input last_of_frame, input status,
                    input close_code, input link_state, output ready);
endinterface

// ===== sv/wfd_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_in_reg
// Input register: holds one received request until the parser takes it.
// ----------------------------------------------------------------------------
module wfd_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    wfd_rx_if.sink           rx,
    input  logic             take,
    output logic             item_valid,
    output wfd_pkg::rx_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    wfd_pkg::rx_item_t item_reg;
    logic              load;

    assign rx.ready   = !valid_reg || take;
    assign load       = rx.valid && rx.ready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.rx_byte  <= rx.rx_byte;
            item_reg.conn_end <= rx.conn_end;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== sv/wfd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_parser
// Frame parse state machine: header, extended length, mask key, unmasking,
// close code capture and link state, with the registered result.
// ----------------------------------------------------------------------------
module wfd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  wfd_pkg::rx_item_t item,
    output logic              take,
    wfd_tx_if.source          tx
);

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    phase_t      phase_reg,      phase_next;
    logic [3:0]  opcode_reg,     opcode_next;
    logic        mask_reg,       mask_next;
    logic [3:0]  len_left_reg,   len_left_next;
    logic [63:0] remain_reg,     remain_next;
    logic [31:0] key_reg,        key_next;
    logic [1:0]  key_cnt_reg,    key_cnt_next;
    logic [1:0]  pos_reg,        pos_next;
    logic [1:0]  close_seen_reg, close_seen_next;
    logic [15:0] close_reg,      close_next;
    logic [1:0]  link_reg,       link_next;

    logic              out_valid_reg, out_valid_next;
    wfd_pkg::tx_item_t out_reg,       out_next;

    logic [7:0]  b;
    logic [7:0]  key_byte;
    logic [7:0]  data;
    logic [31:0] key_shift;
    logic [2:0]  kind_cur;
    logic        done;
    logic        after_len;
    logic [7:0]  res_byte;
    logic        res_valid;
    logic [1:0]  res_status;

    assign take = item_valid && (!out_valid_reg || tx.ready);
    assign b    = item.rx_byte;

    assign key_shift = key_reg >> {~pos_reg, 3'b000};
    assign key_byte  = key_shift[7:0];
    assign data      = mask_reg ? (b ^ key_byte) : b;
    assign kind_cur  = wfd_pkg::kind_of(opcode_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        opcode_next     = opcode_reg;
        mask_next       = mask_reg;
        len_left_next   = len_left_reg;
        remain_next     = remain_reg;
        key_next        = key_reg;
        key_cnt_next    = key_cnt_reg;
        pos_next        = pos_reg;
        close_seen_next = close_seen_reg;
        close_next      = close_reg;
        link_next       = link_reg;
        done            = 1'b0;
        after_len       = 1'b0;
        res_byte        = 8'h00;
        res_valid       = 1'b0;
        res_status      = wfd_pkg::ST_OK;

        if (link_reg == wfd_pkg::LINK_OPEN || link_reg == wfd_pkg::LINK_CLOSING)
        begin
            if (item.conn_end)
            begin
                if (phase_reg == PH_HDR1 || phase_reg == PH_EXTLEN ||
                    phase_reg == PH_KEY || phase_reg == PH_PAYLOAD)
                begin
                    link_next  = wfd_pkg::LINK_ERRORED;
                    res_status = wfd_pkg::ST_DROPPED;
                end
                else
                begin
                    link_next  = wfd_pkg::LINK_CLOSED;
                    res_status = wfd_pkg::ST_PEER_CLOSE;
                end
                phase_next = PH_HDR0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HDR1:
                    begin
                        mask_next       = b[7];
                        key_next        = 32'h0;
                        key_cnt_next    = 2'd0;
                        pos_next        = 2'd0;
                        close_seen_next = 2'd0;
                        if (b[6:0] == wfd_pkg::LEN_EXT64)
                        begin
                            remain_next   = 64'h0;
                            len_left_next = wfd_pkg::EXT64_BYTES;
                            phase_next    = PH_EXTLEN;
                        end
                        else if (b[6:0] == wfd_pkg::LEN_EXT16)
                        begin
                            remain_next   = 64'h0;
                            len_left_next = wfd_pkg::EXT16_BYTES;
                            phase_next    = PH_EXTLEN;
                        end
                        else
                        begin
                            remain_next   = {57'h0, b[6:0]};
                            len_left_next = 4'd0;
                            after_len     = 1'b1;
                        end
                    end
                    PH_EXTLEN:
                    begin
                        remain_next = {remain_reg[55:0], b};
                        if (len_left_reg != 4'd0)
                        begin
                            len_left_next = len_left_reg - 4'd1;
                        end
                        after_len = (len_left_next == 4'd0);
                    end
                    PH_KEY:
                    begin
                        key_next     = {key_reg[23:0], b};
                        key_cnt_next = key_cnt_reg + 2'd1;
                        if (key_cnt_next == 2'd0)
                        begin
                            if (remain_reg == 64'h0)
                            begin
                                done = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        pos_next = pos_reg + 2'd1;
                        if (kind_cur == wfd_pkg::KIND_CLOSE)
                        begin
                            if (close_seen_reg == 2'd0 && (|remain_reg[63:1]))
                            begin
                                close_next[15:8] = data;
                                close_seen_next  = 2'd1;
                            end
                            else if (close_seen_reg == 2'd1)
                            begin
                                close_next[7:0] = data;
                                close_seen_next = 2'd2;
                            end
                        end
                        if (kind_cur <= wfd_pkg::KIND_PING)
                        begin
                            res_byte  = data;
                            res_valid = 1'b1;
                        end
                        if (remain_reg != 64'h0)
                        begin
                            remain_next = remain_reg - 64'd1;
                        end
                        done = (remain_next == 64'h0);
                    end
                    default:
                    begin
                        opcode_next = b[3:0];
                        if (!b[7] || b[3:0] == wfd_pkg::OP_CONT)
                        begin
                            link_next  = wfd_pkg::LINK_ERRORED;
                            res_status = wfd_pkg::ST_FRAGMENTED;
                            phase_next = PH_HDR0;
                        end
                        else
                        begin
                            phase_next = PH_HDR1;
                        end
                    end
                endcase

                if (after_len)
                begin
                    if (mask_next)
                    begin
                        key_cnt_next = 2'd0;
                        phase_next   = PH_KEY;
                    end
                    else if (remain_next == 64'h0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end

                if (done)
                begin
                    phase_next = PH_HDR0;
                    if (opcode_reg == wfd_pkg::OP_CLOSE && link_reg == wfd_pkg::LINK_OPEN)
                    begin
                        link_next = wfd_pkg::LINK_CLOSING;
                    end
                end
            end
        end

        out_next.out_byte      = res_byte;
        out_next.byte_valid    = res_valid;
        out_next.frame_kind    = wfd_pkg::kind_of(opcode_next);
        out_next.last_of_frame = done;
        out_next.status        = res_status;
        out_next.close_code    = close_next;
        out_next.link_state    = link_next;

        out_valid_next = take ? 1'b1 : (tx.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR0;
            opcode_reg     <= 4'h0;
            mask_reg       <= 1'b0;
            len_left_reg   <= 4'd0;
            remain_reg     <= 64'h0;
            key_reg        <= 32'h0;
            key_cnt_reg    <= 2'd0;
            pos_reg        <= 2'd0;
            close_seen_reg <= 2'd0;
            close_reg      <= 16'h0;
            link_reg       <= wfd_pkg::LINK_OPEN;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg      <= phase_next;
                opcode_reg     <= opcode_next;
                mask_reg       <= mask_next;
                len_left_reg   <= len_left_next;
                remain_reg     <= remain_next;
                key_reg        <= key_next;
                key_cnt_reg    <= key_cnt_next;
                pos_reg        <= pos_next;
                close_seen_reg <= close_seen_next;
                close_reg      <= close_next;
                link_reg       <= link_next;
                out_reg        <= out_next;
            end
        end
    end

    assign tx.valid         = out_valid_reg;
    assign tx.out_byte      = out_reg.out_byte;
    assign tx.byte_valid    = out_reg.byte_valid;
    assign tx.frame_kind    = out_reg.frame_kind;
    assign tx.last_of_frame = out_reg.last_of_frame;
    assign tx.status        = out_reg.status;
    assign tx.close_code    = out_reg.close_code;
    assign tx.link_state    = out_reg.link_state;

endmodule

// ===== sv/websocket_frame_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// A request accepted on rx is held in the input register, then parsed into
// the result register, which drives tx.
// Throughput: one request per cycle while tx.ready holds; the parse step is
// a single pass of logic between the input register and the result register.
// Reset (rst_n, async low): link open, parser waits for a first header byte,
// close code zero, both registers empty.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit (
    input  logic     clk,
    input  logic     rst_n,
    wfd_rx_if.sink   rx,
    wfd_tx_if.source tx
);

    logic              take;
    logic              item_valid;
    wfd_pkg::rx_item_t item;

    wfd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    wfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .tx         (tx)
    );

endmodule
